/* rtl/fixed_block_pool_allocator_defines.svh */
// Assertion macros for the checker file of the block pool allocator.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// Concurrent assertion on a given clock, switched off while reset is held.
`define FBPA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("block pool allocator assertion failed");

// The same on the usual clock and reset port names.
`define FBPA_ASSERT_STD(label, prop) \
  `FBPA_ASSERT(label, clk_i, rst_ni, prop)

`endif

/* rtl/fbpa_pkg.sv */
// Types and constants shared by the block pool allocator modules.
`timescale 1ns / 1ps
package fbpa_pkg;

  localparam int BlocksPerPage = 1024;
  localparam int MaxPages      = 8;
  localparam int TotalBlocks   = BlocksPerPage * MaxPages;
  localparam int PageBits      = $clog2(BlocksPerPage);

  localparam int BlockW  = 13;
  localparam int LinkW   = BlockW + 1;
  localparam int CountW  = 11;
  localparam int PagesW  = 4;
  localparam int OpW     = 2;
  localparam int StatusW = 2;

  localparam logic [LinkW-1:0] NullLink = LinkW'(TotalBlocks);

  localparam logic [OpW-1:0] OP_ALLOC_ONE = 2'd0;
  localparam logic [OpW-1:0] OP_ALLOC_RUN = 2'd1;
  localparam logic [OpW-1:0] OP_FREE_ONE  = 2'd2;
  localparam logic [OpW-1:0] OP_FREE_RUN  = 2'd3;

  localparam logic [StatusW-1:0] ST_OK      = 2'd0;
  localparam logic [StatusW-1:0] ST_NOMEM   = 2'd1;
  localparam logic [StatusW-1:0] ST_INVALID = 2'd2;

  // What the current item needs once it has been decoded.
  typedef enum logic [1:0] {
    K_DONE,
    K_POP,
    K_WALK_FREE,
    K_WALK_ALLOC
  } kind_e;

  typedef struct packed {
    logic load;
    logic commit;
    logic pop;
    logic step;
    logic emit_ok;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  walk_last;
    logic  walk_alloc;
    logic  out_free;
  } sts_t;

endpackage

/* rtl/fbpa_ctrl.sv */
// Controller state machine of the block pool allocator.
`timescale 1ns / 1ps
module fbpa_ctrl import fbpa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_WALK,
    S_WDONE
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) || (state_q == S_POP);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    cmd_o.load = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // The item waits here until the output register can take a result.
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          case (sts_i.kind)
            K_POP:        state_d = S_POP;
            K_WALK_FREE:  state_d = S_WALK;
            K_WALK_ALLOC: state_d = S_WALK;
            default:      state_d = S_IDLE;
          endcase
        end
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = accept ? S_EXEC : S_IDLE;
      end
      S_WALK: begin
        cmd_o.step = 1'b1;
        if (sts_i.walk_last) begin
          // The walk is over; an allocation that retired a page remainder is decoded again.
          state_d = sts_i.walk_alloc ? S_EXEC : S_WDONE;
        end
      end
      S_WDONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit_ok = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/fbpa_datapath.sv */
// Datapath of the block pool allocator: pool state, link memory and result register.
`timescale 1ns / 1ps
module fbpa_datapath import fbpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [PagesW-1:0]  cfg_wdata_i,
  input  logic [OpW-1:0]     opcode_i,
  input  logic [BlockW-1:0]  block_i,
  input  logic [CountW-1:0]  count_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [BlockW-1:0]  granted_o,
  output logic [StatusW-1:0] status_o
);

  // Item held during execution.
  logic [OpW-1:0]     op_q;
  logic [BlockW-1:0]  blk_q;
  logic [CountW-1:0]  cnt_q;

  // Pool state.
  logic [LinkW-1:0]   head_q;
  logic [BlockW-1:0]  fresh_next_q;
  logic [CountW-1:0]  fresh_left_q;
  logic [PagesW-1:0]  pages_open_q;
  logic [PagesW-1:0]  page_limit_q;

  // Run linking.
  logic [BlockW-1:0]  w_cur_q;
  logic [BlockW-1:0]  w_first_q;
  logic [CountW-1:0]  w_left_q;
  logic               w_alloc_q;
  logic               w_last;

  // Result register.
  logic               out_valid_q;
  logic [BlockW-1:0]  granted_q;
  logic [StatusW-1:0] status_q;

  // Link memory.
  logic [LinkW-1:0]   link_mem [TotalBlocks];
  logic [LinkW-1:0]   rd_q;
  logic               mem_we;
  logic [BlockW-1:0]  mem_waddr;
  logic [LinkW-1:0]   mem_wdata;

  // Decode.
  logic [LinkW-1:0]   opened;
  logic [LinkW-1:0]   room;
  logic [PagesW-1:0]  eff_limit;
  logic               may_open;
  logic               head_null;
  logic               short_page;
  logic               over_size;
  logic               blk_ok;
  logic               run_ok;
  kind_e              kind;
  logic [StatusW-1:0] dec_status;
  logic [BlockW-1:0]  dec_granted;
  logic               do_alloc;
  logic               do_free1;
  logic               open_pg;
  logic [CountW-1:0]  take;
  logic [BlockW-1:0]  base_next;
  logic [CountW-1:0]  base_left;
  logic               emit;

  assign opened     = {pages_open_q, PageBits'(0)};
  assign room       = opened - {1'b0, blk_q};
  assign eff_limit  = (page_limit_q > PagesW'(MaxPages)) ? PagesW'(MaxPages) : page_limit_q;
  assign may_open   = pages_open_q < eff_limit;
  assign head_null  = (head_q == NullLink);
  assign short_page = cnt_q > fresh_left_q;
  assign over_size  = cnt_q > CountW'(BlocksPerPage);
  assign blk_ok     = {1'b0, blk_q} < opened;
  assign run_ok     = {{(LinkW-CountW){1'b0}}, cnt_q} <= room;

  always_comb begin
    kind        = K_DONE;
    dec_status  = ST_OK;
    dec_granted = '0;
    do_alloc    = 1'b0;
    do_free1    = 1'b0;
    open_pg     = 1'b0;
    take        = '0;
    case (op_q)
      OP_ALLOC_ONE: begin
        if (!head_null) begin
          kind        = K_POP;
          dec_granted = head_q[BlockW-1:0];
        end else if (fresh_left_q == '0 && !may_open) begin
          dec_status = ST_NOMEM;
        end else begin
          do_alloc = 1'b1;
          take     = CountW'(1);
          open_pg  = (fresh_left_q == '0);
        end
      end
      OP_ALLOC_RUN: begin
        if (over_size) begin
          dec_status = ST_INVALID;
        end else if (short_page && !may_open) begin
          dec_status = ST_NOMEM;
        end else if (short_page && fresh_left_q != '0) begin
          kind = K_WALK_ALLOC;
        end else begin
          do_alloc = 1'b1;
          take     = cnt_q;
          open_pg  = short_page;
        end
      end
      OP_FREE_ONE: begin
        if (!blk_ok) begin
          dec_status = ST_INVALID;
        end else begin
          do_free1 = 1'b1;
        end
      end
      default: begin
        if (cnt_q == '0 || over_size || !blk_ok || !run_ok) begin
          dec_status = ST_INVALID;
        end else begin
          kind = K_WALK_FREE;
        end
      end
    endcase
    base_next = open_pg ? BlockW'(opened) : fresh_next_q;
    base_left = open_pg ? CountW'(BlocksPerPage) : fresh_left_q;
    if (do_alloc) begin
      dec_granted = base_next;
    end
  end

  assign w_last = (w_left_q == CountW'(1));

  assign emit = (cmd_i.commit && kind != K_WALK_FREE && kind != K_WALK_ALLOC) ||
                cmd_i.emit_ok;

  // The one write port serves a single free and each link of a run.
  assign mem_we    = (cmd_i.commit && do_free1) || cmd_i.step;
  assign mem_waddr = cmd_i.step ? w_cur_q : blk_q;
  assign mem_wdata = (!cmd_i.step || w_last) ? head_q : ({1'b0, w_cur_q} + LinkW'(1));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= link_mem[head_q[BlockW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      blk_q <= block_i;
      cnt_q <= count_i;
    end
    if (cmd_i.commit && (kind == K_WALK_FREE || kind == K_WALK_ALLOC)) begin
      w_alloc_q <= (kind == K_WALK_ALLOC);
      w_cur_q   <= (kind == K_WALK_ALLOC) ? fresh_next_q : blk_q;
      w_first_q <= (kind == K_WALK_ALLOC) ? fresh_next_q : blk_q;
      w_left_q  <= (kind == K_WALK_ALLOC) ? fresh_left_q : cnt_q;
    end else if (cmd_i.step) begin
      w_cur_q  <= w_cur_q + BlockW'(1);
      w_left_q <= w_left_q - CountW'(1);
    end
    if (emit) begin
      granted_q <= cmd_i.emit_ok ? '0 : dec_granted;
      status_q  <= cmd_i.emit_ok ? ST_OK : dec_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= NullLink;
      fresh_next_q <= '0;
      fresh_left_q <= CountW'(BlocksPerPage);
      pages_open_q <= PagesW'(1);
      page_limit_q <= PagesW'(MaxPages);
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        page_limit_q <= cfg_wdata_i;
      end
      if (cmd_i.commit && do_alloc) begin
        fresh_next_q <= base_next + BlockW'(take);
        fresh_left_q <= base_left - take;
        if (open_pg) begin
          pages_open_q <= pages_open_q + PagesW'(1);
        end
      end
      if (cmd_i.commit && do_free1) begin
        head_q <= {1'b0, blk_q};
      end
      if (cmd_i.pop) begin
        head_q <= rd_q;
      end
      if (cmd_i.step && w_last) begin
        head_q <= {1'b0, w_first_q};
        // A retired page remainder leaves nothing fresh in that page.
        if (w_alloc_q) begin
          fresh_left_q <= '0;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.kind       = kind;
  assign sts_o.walk_last  = w_last;
  assign sts_o.walk_alloc = w_alloc_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign granted_o   = granted_q;
  assign status_o    = status_q;

endmodule

/* rtl/fixed_block_pool_allocator.sv */
// Top level of the fixed-size block pool allocator.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i/in_ready_o   opcode_i, block_i, count_i
//   out       output     out_valid_o/out_ready_i granted_o, status_o
//   cfg       input      cfg_we_i                cfg_wdata_i (page limit)
//
// Single allocations, single frees and allocations from the fresh region are decided in the
// execute state; a pop's link memory read overlaps the next input transfer.
// A run free links its blocks in the walk state, and an allocation that retires a page
// remainder walks it first, both paced by the single write port of the link memory.
// Reset needs no clearing pass: every link is written before it is followed.
// A result that is not taken holds the next item in its execute state.
`timescale 1ns / 1ps
module fixed_block_pool_allocator import fbpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [PagesW-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [OpW-1:0]     opcode_i,
  input  logic [BlockW-1:0]  block_i,
  input  logic [CountW-1:0]  count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [BlockW-1:0]  granted_o,
  output logic [StatusW-1:0] status_o
);

  cmd_t cmd;
  sts_t sts;

  fbpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fbpa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .opcode_i    (opcode_i),
    .block_i     (block_i),
    .count_i     (count_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .granted_o   (granted_o),
    .status_o    (status_o)
  );

endmodule

/* rtl/fbpa_checker.sv */
// Port-level checker of the block pool allocator and its bind to the top level.
`timescale 1ns / 1ps
`include "fixed_block_pool_allocator_defines.svh"
module fbpa_checker import fbpa_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [PagesW-1:0]  cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [OpW-1:0]     opcode_i,
  input logic [BlockW-1:0]  block_i,
  input logic [CountW-1:0]  count_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [BlockW-1:0]  granted_o,
  input logic [StatusW-1:0] status_o
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pending_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // Items taken in whose result has not yet been transferred out.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  `FBPA_ASSERT_STD(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(granted_o) && $stable(status_o))
  `FBPA_ASSERT_STD(a_fail_grants_zero, out_valid_o && status_o != ST_OK |-> granted_o == '0)
  `FBPA_ASSERT_STD(a_no_invented_result, out_valid_o |-> pending_q != 2'd0)
  `FBPA_ASSERT_STD(a_busy_after_transfer, in_xfer |=> !in_ready_o)

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);

/* verif/fixed_block_pool_allocator_tb.sv */
// Self-checking testbench for the fixed-size block pool allocator.
`timescale 1ns / 1ps
module fixed_block_pool_allocator_tb;
  import fbpa_pkg::*;

  localparam int  HeadRows    = 27;
  localparam int  NumRows     = 31;
  localparam int  NumPhases   = 8;
  localparam int  PhaseItems  = 112;
  localparam int  IdlePercent = 28;
  localparam real TimeoutNs   = 10_000_000.0;

  typedef struct packed {
    logic [BlockW-1:0]  granted;
    logic [StatusW-1:0] status;
  } response_t;

  typedef struct packed {
    logic               is_cfg;
    logic [PagesW-1:0]  limit;
    logic [OpW-1:0]     op;
    logic [BlockW-1:0]  blk;
    logic [CountW-1:0]  cnt;
    logic               known;
    logic [BlockW-1:0]  granted;
    logic [StatusW-1:0] status;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [PagesW-1:0]  cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [OpW-1:0]     opcode_i;
  logic [BlockW-1:0]  block_i;
  logic [CountW-1:0]  count_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [BlockW-1:0]  granted_o;
  logic [StatusW-1:0] status_o;

  // Shadow of the pool state.
  logic [LinkW-1:0]  link_mem [TotalBlocks];
  logic [LinkW-1:0]  stack_top;
  logic [LinkW-1:0]  fresh_at;
  logic [CountW-1:0] fresh_room;
  logic [PagesW-1:0] pages_used;
  logic [PagesW-1:0] limit_reg;

  response_t   owed[$];
  int unsigned held_first[$];
  int unsigned held_len[$];
  int          mismatches;
  bit          steady;

  logic [PagesW-1:0] phase_limit [NumPhases] = '{
    4'd2, 4'd8, 4'd0, 4'd15, 4'd4, 4'd1, 4'd6, 4'd8
  };

  // The rows after HeadRows free one block twice, which leaves a loop in the
  // free list for good, so they are walked only once the random part is over.
  plan_row_t plan [NumRows] = '{
    '{1'b1, 4'd1, OP_ALLOC_ONE, 13'd0,    11'd0,    1'b0, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_ALLOC_RUN, 13'd0,    11'd1024, 1'b1, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_ALLOC_ONE, 13'd0,    11'd0,    1'b1, 13'd0,    ST_NOMEM},
    '{1'b0, 4'd0, OP_ALLOC_RUN, 13'd0,    11'd1,    1'b1, 13'd0,    ST_NOMEM},
    '{1'b0, 4'd0, OP_ALLOC_RUN, 13'd0,    11'd0,    1'b1, 13'd1024, ST_OK},
    '{1'b0, 4'd0, OP_ALLOC_RUN, 13'd0,    11'd1025, 1'b1, 13'd0,    ST_INVALID},
    '{1'b0, 4'd0, OP_ALLOC_RUN, 13'd8191, 11'd2047, 1'b1, 13'd0,    ST_INVALID},
    '{1'b0, 4'd0, OP_FREE_ONE,  13'd1024, 11'd0,    1'b1, 13'd0,    ST_INVALID},
    '{1'b0, 4'd0, OP_FREE_ONE,  13'd8191, 11'd2047, 1'b1, 13'd0,    ST_INVALID},
    '{1'b0, 4'd0, OP_FREE_RUN,  13'd0,    11'd0,    1'b1, 13'd0,    ST_INVALID},
    '{1'b0, 4'd0, OP_FREE_RUN,  13'd1000, 11'd100,  1'b1, 13'd0,    ST_INVALID},
    '{1'b0, 4'd0, OP_FREE_RUN,  13'd0,    11'd1025, 1'b1, 13'd0,    ST_INVALID},
    '{1'b0, 4'd0, OP_FREE_ONE,  13'd1023, 11'd0,    1'b1, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_ALLOC_ONE, 13'd0,    11'd0,    1'b0, 13'd0,    ST_OK},
    '{1'b1, 4'd8, OP_ALLOC_ONE, 13'd0,    11'd0,    1'b0, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_ALLOC_RUN, 13'd0,    11'd1024, 1'b0, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_ALLOC_ONE, 13'd0,    11'd0,    1'b0, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_ALLOC_RUN, 13'd0,    11'd5,    1'b0, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_ALLOC_RUN, 13'd0,    11'd1020, 1'b0, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_ALLOC_ONE, 13'd0,    11'd0,    1'b0, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_FREE_RUN,  13'd1024, 11'd1024, 1'b1, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_FREE_ONE,  13'd0,    11'd0,    1'b1, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_FREE_RUN,  13'd3072, 11'd1020, 1'b1, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_FREE_RUN,  13'd4000, 11'd97,   1'b1, 13'd0,    ST_INVALID},
    '{1'b0, 4'd0, OP_FREE_ONE,  13'd4096, 11'd0,    1'b1, 13'd0,    ST_INVALID},
    '{1'b0, 4'd0, OP_ALLOC_ONE, 13'd0,    11'd0,    1'b0, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_ALLOC_ONE, 13'd0,    11'd0,    1'b0, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_FREE_ONE,  13'd0,    11'd0,    1'b0, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_FREE_ONE,  13'd0,    11'd0,    1'b0, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_ALLOC_ONE, 13'd0,    11'd0,    1'b0, 13'd0,    ST_OK},
    '{1'b0, 4'd0, OP_ALLOC_ONE, 13'd0,    11'd0,    1'b0, 13'd0,    ST_OK}
  };

  fixed_block_pool_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .block_i     (block_i),
    .count_i     (count_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .granted_o   (granted_o),
    .status_o    (status_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic bit page_available();
    int unsigned lim;
    lim = (limit_reg < MaxPages) ? limit_reg : MaxPages;
    return pages_used < lim;
  endfunction

  function automatic void start_page();
    fresh_at   = LinkW'(pages_used * BlocksPerPage);
    fresh_room = CountW'(BlocksPerPage);
    pages_used = pages_used + 1'b1;
  endfunction

  // Chains first..first+n-1 in order and puts the chain on top of the free list.
  function automatic void push_chain(int unsigned first, int unsigned n);
    int unsigned i;
    for (i = 0; i + 1 < n; i++) begin
      link_mem[first + i] = LinkW'(first + i + 1);
    end
    link_mem[first + n - 1] = stack_top;
    stack_top = LinkW'(first);
  endfunction

  function automatic response_t pool_outcome(logic [OpW-1:0] op, logic [BlockW-1:0] blk,
                                             logic [CountW-1:0] cnt);
    response_t   res;
    int unsigned opened;
    int unsigned n;
    int unsigned b;
    res    = '0;
    res.status = ST_OK;
    n      = cnt;
    b      = blk;
    opened = pages_used * BlocksPerPage;
    case (op)
      OP_ALLOC_ONE: begin
        if (stack_top < TotalBlocks) begin
          res.granted = stack_top[BlockW-1:0];
          stack_top   = link_mem[stack_top];
        end else if (fresh_room == 0 && !page_available()) begin
          res.status = ST_NOMEM;
        end else begin
          if (fresh_room == 0) start_page();
          res.granted = fresh_at[BlockW-1:0];
          fresh_at    = fresh_at + 1'b1;
          fresh_room  = fresh_room - 1'b1;
        end
      end
      OP_ALLOC_RUN: begin
        if (n > BlocksPerPage) begin
          res.status = ST_INVALID;
        end else if (n > fresh_room && !page_available()) begin
          res.status = ST_NOMEM;
        end else begin
          // A page too short for the run gives its tail back to the free list.
          if (n > fresh_room) begin
            if (fresh_room != 0) push_chain(fresh_at, fresh_room);
            start_page();
          end
          res.granted = fresh_at[BlockW-1:0];
          fresh_at    = fresh_at + LinkW'(n);
          fresh_room  = fresh_room - CountW'(n);
        end
      end
      OP_FREE_ONE: begin
        if (b >= opened) begin
          res.status = ST_INVALID;
        end else begin
          link_mem[b] = stack_top;
          stack_top   = LinkW'(b);
        end
      end
      default: begin
        if (n == 0 || n > BlocksPerPage || b >= opened || n > opened - b) begin
          res.status = ST_INVALID;
        end else begin
          push_chain(b, n);
        end
      end
    endcase
    return res;
  endfunction

  task automatic log_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%t: %s", $realtime, what);
  endtask

  // Waits at a falling edge until every response is in, then a short settling pause.
  task automatic wait_drained();
    while (owed.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [PagesW-1:0] value);
    in_valid_i <= 1'b0;
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    limit_reg = value;
  endtask

  // Offers one request at a falling edge and returns once it has been transferred.
  task automatic transfer_item(input logic [OpW-1:0] op, input logic [BlockW-1:0] blk,
                               input logic [CountW-1:0] cnt, input bit typed,
                               input response_t typed_res, output response_t outcome);
    while (!steady && $urandom_range(99) < IdlePercent) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    block_i    <= blk;
    count_i    <= cnt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    outcome = pool_outcome(op, blk, cnt);
    owed.push_back(typed ? typed_res : outcome);
    @(negedge clk_i);
  endtask

  task automatic run_row(input plan_row_t row);
    response_t typed_res;
    response_t outcome;
    typed_res.granted = row.granted;
    typed_res.status  = row.status;
    if (row.is_cfg) begin
      write_limit(row.limit);
    end else begin
      transfer_item(row.op, row.blk, row.cnt, row.known, typed_res, outcome);
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= IdlePercent);
  end

  always @(posedge clk_i) begin : check_responses
    response_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed.size() == 0) begin
        log_mismatch($sformatf("unexpected response: granted %0d status %0d",
                               granted_o, status_o));
      end else begin
        want = owed.pop_front();
        if (granted_o !== want.granted || status_o !== want.status) begin
          log_mismatch($sformatf("expected granted %0d status %0d, got granted %0d status %0d",
                                 want.granted, want.status, granted_o, status_o));
        end
      end
    end
  end

  initial begin : stimulus
    response_t         outcome;
    logic [OpW-1:0]    op;
    logic [BlockW-1:0] blk;
    logic [CountW-1:0] cnt;
    int unsigned       pick;
    int unsigned       sel;
    int unsigned       n;
    int unsigned       b;
    int                phase;
    int                k;

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    opcode_i    = OP_ALLOC_ONE;
    block_i     = '0;
    count_i     = '0;
    out_ready_i = 1'b0;
    steady      = 1'b0;
    mismatches  = 0;
    stack_top   = NullLink;
    fresh_at    = '0;
    fresh_room  = CountW'(BlocksPerPage);
    pages_used  = PagesW'(1);
    limit_reg   = PagesW'(MaxPages);

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (k = 0; k < HeadRows; k++) run_row(plan[k]);

    for (phase = 0; phase < NumPhases; phase++) begin
      write_limit(phase_limit[phase]);
      // One whole phase runs without any idling on either side.
      steady = (phase == 3);
      for (k = 0; k < PhaseItems; k++) begin
        pick = $urandom_range(99);
        if (pick >= 33 && pick < 88 && held_first.size() == 0) pick = 0;
        blk = BlockW'($urandom_range(8191));
        cnt = CountW'($urandom_range(2047));
        if (pick < 33) begin
          op = OP_ALLOC_ONE;
        end else if (pick < 55) begin
          op  = OP_ALLOC_RUN;
          sel = $urandom_range(99);
          if (sel < 5) cnt = '0;
          else if (sel < 70) cnt = CountW'($urandom_range(16, 1));
          else if (sel < 90) cnt = CountW'($urandom_range(300, 17));
          else cnt = CountW'($urandom_range(BlocksPerPage, 301));
        end else if (pick < 88) begin
          // Give back something that is really held: a whole run, or its first block.
          sel = $urandom_range(held_first.size() - 1);
          b   = held_first[sel];
          n   = held_len[sel];
          blk = BlockW'(b);
          if (n > 1 && $urandom_range(9) < 3) begin
            op = OP_FREE_ONE;
            held_first[sel] = b + 1;
            held_len[sel]   = n - 1;
          end else begin
            op = (n == 1 && $urandom_range(1) == 0) ? OP_FREE_ONE : OP_FREE_RUN;
            if (op == OP_FREE_RUN) cnt = CountW'(n);
            held_first.delete(sel);
            held_len.delete(sel);
          end
        end else begin
          sel = $urandom_range(2);
          if (sel == 0) begin
            op  = OP_ALLOC_RUN;
            cnt = CountW'($urandom_range(2047, BlocksPerPage + 1));
          end else if (sel == 1 || pages_used >= MaxPages) begin
            op  = OP_FREE_RUN;
            cnt = (sel == 1) ? '0 : CountW'($urandom_range(2047, BlocksPerPage + 1));
          end else begin
            op  = OP_FREE_ONE;
            blk = BlockW'($urandom_range(TotalBlocks - 1, pages_used * BlocksPerPage));
          end
        end
        transfer_item(op, blk, cnt, 1'b0, '0, outcome);
        if (outcome.status == ST_OK) begin
          if (op == OP_ALLOC_ONE) begin
            held_first.push_back(outcome.granted);
            held_len.push_back(1);
          end else if (op == OP_ALLOC_RUN && cnt != 0) begin
            held_first.push_back(outcome.granted);
            held_len.push_back(cnt);
          end
        end
      end
    end
    steady = 1'b0;

    for (k = HeadRows; k < NumRows; k++) run_row(plan[k]);

    in_valid_i <= 1'b0;
    while (owed.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (mismatches == 0 && owed.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/fbpa_pkg.sv
rtl/fbpa_ctrl.sv
rtl/fbpa_datapath.sv
rtl/fixed_block_pool_allocator.sv
rtl/fbpa_checker.sv
verif/fixed_block_pool_allocator_tb.sv
